### rtl/kpl_pkg.sv
// Package for the keypad PIN lock controller: PIN size, key and event codes,
// result type and reset PIN. No dependencies.
package kpl_pkg;

  localparam int unsigned PIN_DIGITS = 5;
  localparam int unsigned CNT_W = $clog2(PIN_DIGITS + 1);
  localparam int unsigned IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int unsigned TICK_W = 16;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_CLEAR = 4'd10;
  localparam logic [3:0] KEY_LOCK = 4'd11;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_WRONG = 3'd1,
    EV_UNLOCKED = 3'd2,
    EV_RELOCKED = 3'd3,
    EV_CHANGED = 3'd4,
    EV_MISMATCH = 3'd5,
    EV_REFUSED = 3'd6
  } ev_e;

  typedef logic [PIN_DIGITS-1:0][3:0] pin_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] digits_entered;
    logic       door_locked;
    logic       green_light;
    logic       red_light;
    logic       yellow_light;
    logic [2:0] event_status;
  } res_t;

  function automatic pin_t reset_pin();
    pin_t p;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      p[i] = 4'(i + 1);
    end
    return p;
  endfunction

endpackage

### rtl/kpl_key_if.sv
// Key/tick input channel: valid/ready handshake with opcode and key code.
// Depends on nothing.
interface kpl_key_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] key_code;

  modport source (output valid, output opcode, output key_code, input ready);
  modport sink (input valid, input opcode, input key_code, output ready);
endinterface

### rtl/kpl_res_if.sv
// Result channel: valid/ready handshake with lock status fields.
// Depends on nothing.
interface kpl_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [2:0] digits_entered;
  logic       door_locked;
  logic       green_light;
  logic       red_light;
  logic       yellow_light;
  logic [2:0] event_status;

  modport source (
    output valid, output mode, output digits_entered, output door_locked,
    output green_light, output red_light, output yellow_light, output event_status,
    input ready
  );
  modport sink (
    input valid, input mode, input digits_entered, input door_locked,
    input green_light, input red_light, input yellow_light, input event_status,
    output ready
  );
endinterface

### rtl/kpl_engine.sv
// Lock state registers and next-state logic for one item per cycle while step_i is high.
// Depends on kpl_pkg.
module kpl_engine
  import kpl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              opcode_i,
  input  logic [3:0]        key_code_i,
  input  logic [TICK_W-1:0] timeout_i,
  output res_t              res_o
);

  typedef enum logic [2:0] {
    MODE_ENTER = 3'd0,
    MODE_CURRENT = 3'd1,
    MODE_NEW = 3'd2,
    MODE_CONFIRM = 3'd3,
    MODE_OPEN = 3'd4
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  pin_t              stored_q, stored_d;
  pin_t              entry_q, entry_d;
  pin_t              prop_q, prop_d;
  pin_t              entry_new;
  ev_e               ev;
  logic              is_zero, hit_stored, hit_prop, open;

  assign is_zero = (entry_new == '0);
  assign hit_stored = (entry_new == stored_q);
  assign hit_prop = (entry_new == prop_q);

  always_comb begin
    mode_d = mode_q;
    cnt_d = cnt_q;
    elapsed_d = elapsed_q;
    stored_d = stored_q;
    entry_d = entry_q;
    prop_d = prop_q;
    entry_new = entry_q;
    ev = EV_NONE;
    if (!opcode_i && key_code_i <= KEY_DIGIT_MAX) begin
      entry_new[cnt_q[IDX_W-1:0]] = key_code_i;
    end
    if (mode_q == MODE_OPEN) begin
      if (opcode_i == OP_TICK) begin
        elapsed_d = elapsed_q + 1'b1;
        if (elapsed_d >= timeout_i) begin
          mode_d = MODE_ENTER;
          cnt_d = '0;
          ev = EV_RELOCKED;
        end
      end else if (key_code_i == KEY_LOCK) begin
        mode_d = MODE_ENTER;
        cnt_d = '0;
        ev = EV_RELOCKED;
      end
    end else if (opcode_i == OP_KEY) begin
      if (key_code_i <= KEY_DIGIT_MAX) begin
        entry_d = entry_new;
        if (cnt_q == CNT_W'(PIN_DIGITS - 1)) begin
          cnt_d = '0;
          case (mode_q)
            MODE_ENTER: begin
              if (is_zero) begin
                mode_d = MODE_CURRENT;
              end else if (hit_stored) begin
                mode_d = MODE_OPEN;
                elapsed_d = '0;
                ev = EV_UNLOCKED;
              end else begin
                ev = EV_WRONG;
              end
            end
            MODE_CURRENT: begin
              if (hit_stored) begin
                mode_d = MODE_NEW;
              end else begin
                mode_d = MODE_ENTER;
                ev = EV_WRONG;
              end
            end
            MODE_NEW: begin
              if (is_zero) begin
                mode_d = MODE_ENTER;
                ev = EV_REFUSED;
              end else begin
                prop_d = entry_new;
                mode_d = MODE_CONFIRM;
              end
            end
            default: begin
              if (hit_prop) begin
                stored_d = prop_q;
                ev = EV_CHANGED;
              end else begin
                ev = EV_MISMATCH;
              end
              mode_d = MODE_ENTER;
            end
          endcase
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end else if (key_code_i == KEY_CLEAR && cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  assign open = (mode_d == MODE_OPEN);
  always_comb begin
    res_o.mode = mode_d;
    res_o.digits_entered = open ? 3'd0 : 3'(cnt_d);
    res_o.door_locked = !open;
    res_o.green_light = open;
    res_o.red_light = !open;
    res_o.yellow_light = (mode_d == MODE_NEW) || (mode_d == MODE_CONFIRM);
    res_o.event_status = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENTER;
      cnt_q <= '0;
      elapsed_q <= '0;
      stored_q <= reset_pin();
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q <= cnt_d;
      elapsed_q <= elapsed_d;
      stored_q <= stored_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      entry_q <= entry_d;
      prop_q <= prop_d;
    end
  end

  a_cnt_short : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(PIN_DIGITS)) else $error("entry count reached full");
  a_unlock_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev == EV_UNLOCKED |=> elapsed_q == '0 && mode_q == MODE_OPEN)
    else $error("unlock did not clear tick count");
  a_relock : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev == EV_RELOCKED |=> mode_q == MODE_ENTER && cnt_q == '0)
    else $error("relock left stale state");
  a_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev == EV_CHANGED |=> stored_q == $past(prop_q))
    else $error("changed PIN not stored");

endmodule

### rtl/keypad_pin_lock_controller.sv
// Keypad PIN lock controller: each key or tick item yields one status item.
// The block takes one item per clock unless the output stalls; an item
// goes from the input register through next-state logic into the result
// register. Input ready follows result ready combinationally, so under
// output stall one further item is held in the input register. The unlock
// timeout is written through cfg_we_i/cfg_wdata_i and resets to 100 ticks.
// Depends on kpl_pkg, kpl_key_if, kpl_res_if and kpl_engine.
module keypad_pin_lock_controller
  import kpl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  kpl_key_if.sink           in_if,
  kpl_res_if.source         out_if,
  input  logic              cfg_we_i,
  input  logic [TICK_W-1:0] cfg_wdata_i
);

  logic              s1_valid_q;
  logic              s1_opcode_q;
  logic [3:0]        s1_key_q;
  logic              out_valid_q;
  res_t              out_res_q;
  res_t              res_next;
  logic [TICK_W-1:0] timeout_q;
  logic              in_acc, s1_go, out_free;

  assign out_free = !out_valid_q || out_if.ready;
  assign s1_go = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || s1_go;
  assign in_acc = in_if.valid && in_if.ready;

  kpl_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_go),
    .opcode_i   (s1_opcode_q),
    .key_code_i (s1_key_q),
    .timeout_i  (timeout_q),
    .res_o      (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_opcode_q <= in_if.opcode;
      s1_key_q <= in_if.key_code;
    end
    if (s1_go) begin
      out_res_q <= res_next;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.mode = out_res_q.mode;
  assign out_if.digits_entered = out_res_q.digits_entered;
  assign out_if.door_locked = out_res_q.door_locked;
  assign out_if.green_light = out_res_q.green_light;
  assign out_if.red_light = out_res_q.red_light;
  assign out_if.yellow_light = out_res_q.yellow_light;
  assign out_if.event_status = out_res_q.event_status;

  a_in_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q) else $error("accepted item lost");
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_if.ready |=> s1_valid_q && $stable(s1_key_q))
    else $error("pending item dropped under stall");
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_valid_q) else $error("result not registered");

endmodule
